[rtl/jsu_pkg.sv]
// shared types, constants and helpers of the json string unescaper
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

	// width of the per-string byte count
	localparam int COUNT_BITS = 16;
	// count arithmetic width, one bit above the widest operand
	localparam int LIM_W = ((COUNT_BITS > 16) ? COUNT_BITS : 16) + 1;

	localparam logic [15:0] CAP_RESET = 16'd256;

	// command queue between front and back
	localparam int Q_DEPTH = 4;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// escape modes
	localparam logic [2:0] MODE_TEXT   = 3'd0;
	localparam logic [2:0] MODE_ESC    = 3'd1;
	localparam logic [2:0] MODE_HEX1   = 3'd2;
	localparam logic [2:0] MODE_LOW_BS = 3'd3;
	localparam logic [2:0] MODE_LOW_U  = 3'd4;
	localparam logic [2:0] MODE_HEX2   = 3'd5;

	// characters
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_LOW_U  = 8'h75;
	localparam logic [7:0] CH_LOW_N  = 8'h6E;
	localparam logic [7:0] CH_LOW_T  = 8'h74;
	localparam logic [7:0] CH_LOW_R  = 8'h72;
	localparam logic [7:0] CH_LOW_B  = 8'h62;
	localparam logic [7:0] CH_LOW_F  = 8'h66;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_BS     = 8'h08;
	localparam logic [7:0] CH_FF     = 8'h0C;

	// utf-8 lead and continuation marks
	localparam logic [7:0] UTF_CONT = 8'h80;
	localparam logic [7:0] UTF_LEAD2 = 8'hC0;
	localparam logic [7:0] UTF_LEAD3 = 8'hE0;
	localparam logic [7:0] UTF_LEAD4 = 8'hF0;

	// surrogate bounds
	localparam logic [15:0] SUR_LO     = 16'hD800;
	localparam logic [15:0] SUR_HI_END = 16'hDBFF;
	localparam logic [15:0] SUR_LOW    = 16'hDC00;
	localparam logic [15:0] SUR_END    = 16'hDFFF;
	localparam logic [20:0] SUPP_BASE  = 21'h10000;

	// config register index
	localparam logic REG_CAPACITY = 1'b0;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       byte_valid;
		logic       string_end;
	} in_item_t;

	typedef struct packed {
		logic [7:0]  out_byte;
		logic        run_last;
		logic        is_end;
		logic [15:0] out_length;
	} out_item_t;

	// all results caused by one input beat
	typedef struct packed {
		logic [2:0]      nbytes;
		logic [3:0][7:0] data;
		logic            has_end;
		logic [15:0]     length;
	} cmd_t;

	// {valid, value}
	function automatic logic [4:0] hex_val(input logic [7:0] b);
		logic [4:0] r;
		r = 5'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r = {1'b1, 4'(b - 8'h30)};
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r = {1'b1, 4'(b - 8'h57)};
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r = {1'b1, 4'(b - 8'h37)};
		end
		return r;
	endfunction

	function automatic logic room(input logic [LIM_W-1:0] c, input logic [LIM_W-1:0] lim,
			input logic [2:0] k);
		return (c + LIM_W'(k)) < lim;
	endfunction

endpackage

`default_nettype wire

[rtl/json_string_unescape_utf8_top.sv]
// JSON string body unescaper producing UTF-8, top level
//
// item channel: one raw body byte per beat (item_valid / item_stall); a beat
// with string_end closes the string and may also carry a byte.
// result channel: one output byte per beat, plus a final end beat with the
// byte count; run_last marks the last beat caused by one input beat.
// apb port: register 0 (address 0) is out_capacity, reset 256.
// path: commands pass the queue register, then the result register.
// throughput: one input beat per cycle while each beat yields at most one
// result and no result stall; the back end delivers one result per cycle
// unless stalled, so a beat yielding n results (up to 5, e.g. a surrogate
// pair followed by the end) holds the result side for n results, absorbed
// by the 4-entry command queue; item_stall rises only when it is full.
// reset clears the escape state, the count and the queue; capacity -> 256.
// a stalled result beat is held unchanged until taken.
`timescale 1ns / 1ps
`default_nettype none

module json_string_unescape_utf8_top (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire jsu_pkg::in_item_t item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output jsu_pkg::out_item_t     result
);

	logic [15:0]   cap_q;
	jsu_pkg::cmd_t cmd, head;
	logic          push, pop, nonempty, full;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == jsu_pkg::REG_CAPACITY) ? {16'd0, cap_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= jsu_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && paddr[2] == jsu_pkg::REG_CAPACITY) begin
			cap_q <= pwdata[15:0];
		end
	end

	assign item_stall = full;

	jsu_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item       (item),
		.capacity   (cap_q),
		.full       (full),
		.cmd        (cmd),
		.push       (push)
	);

	jsu_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wdata    (cmd),
		.pop      (pop),
		.head     (head),
		.nonempty (nonempty),
		.full     (full)
	);

	jsu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.nonempty     (nonempty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

endmodule

`default_nettype wire

[rtl/jsu_front.sv]
// front end: decodes escapes per beat and builds a command of result bytes
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	input  wire jsu_pkg::in_item_t item,
	input  wire logic [15:0]       capacity,
	input  wire logic              full,
	output jsu_pkg::cmd_t          cmd,
	output logic                   push
);

	logic [2:0]                     mode_q, mode_n;
	logic [2:0]                     hc_q, hc_n;
	logic [15:0]                    u1_q, u1_n;
	logic [15:0]                    u2_q, u2_n;
	logic [jsu_pkg::COUNT_BITS-1:0] cnt_q;
	logic                           stop_q, stop_n;

	logic                           accept;
	logic [jsu_pkg::LIM_W-1:0]      lim, cap_ext, pow;
	logic [jsu_pkg::LIM_W-1:0]      c;
	logic [2:0]                     n;
	logic [3:0][7:0]                ob;
	logic                           do_text, esc_follow, do_esc;
	logic [7:0]                     tb, b, m;
	logic [4:0]                     hv;
	logic [20:0]                    cp;

	assign accept  = item_valid && !full;
	assign b       = item.in_byte;
	assign hv      = jsu_pkg::hex_val(item.in_byte);
	assign cap_ext = jsu_pkg::LIM_W'(capacity);
	assign pow     = jsu_pkg::LIM_W'(1) << jsu_pkg::COUNT_BITS;
	assign lim     = (cap_ext < pow) ? cap_ext : pow;

	always_comb begin
		mode_n     = mode_q;
		hc_n       = hc_q;
		u1_n       = u1_q;
		u2_n       = u2_q;
		stop_n     = stop_q;
		c          = jsu_pkg::LIM_W'(cnt_q);
		n          = 3'd0;
		ob         = '0;
		do_text    = 1'b0;
		esc_follow = 1'b0;
		do_esc     = 1'b0;
		tb         = b;
		m          = b;
		cp         = '0;

		if (item.byte_valid && !stop_q) begin
			unique case (mode_q)
				jsu_pkg::MODE_ESC: begin
					do_esc = 1'b1;
				end
				jsu_pkg::MODE_HEX1: begin
					if (!hv[4]) begin
						mode_n = jsu_pkg::MODE_TEXT;
					end else begin
						u1_n = {u1_q[11:0], hv[3:0]};
						hc_n = hc_q + 3'd1;
						if (hc_q == 3'd3) begin
							mode_n = jsu_pkg::MODE_TEXT;
							if (u1_n < 16'h0080) begin
								if (jsu_pkg::room(c, lim, 3'd1)) begin
									ob[n[1:0]] = u1_n[7:0]; n = n + 3'd1; c = c + 1'b1;
								end
							end else if (u1_n < 16'h0800) begin
								if (jsu_pkg::room(c, lim, 3'd2)) begin
									ob[n[1:0]] = jsu_pkg::UTF_LEAD2 | {3'd0, u1_n[10:6]};
									n = n + 3'd1; c = c + 1'b1;
									ob[n[1:0]] = jsu_pkg::UTF_CONT | {2'd0, u1_n[5:0]};
									n = n + 3'd1; c = c + 1'b1;
								end
							end else if (u1_n >= jsu_pkg::SUR_LO && u1_n <= jsu_pkg::SUR_END) begin
								// surrogate: look ahead for a low half
								mode_n = jsu_pkg::MODE_LOW_BS;
							end else if (jsu_pkg::room(c, lim, 3'd3)) begin
								ob[n[1:0]] = jsu_pkg::UTF_LEAD3 | {4'd0, u1_n[15:12]};
								n = n + 3'd1; c = c + 1'b1;
								ob[n[1:0]] = jsu_pkg::UTF_CONT | {2'd0, u1_n[11:6]};
								n = n + 3'd1; c = c + 1'b1;
								ob[n[1:0]] = jsu_pkg::UTF_CONT | {2'd0, u1_n[5:0]};
								n = n + 3'd1; c = c + 1'b1;
							end
						end
					end
				end
				jsu_pkg::MODE_LOW_BS: begin
					if (b == jsu_pkg::CH_BSLASH) begin
						mode_n = jsu_pkg::MODE_LOW_U;
					end else begin
						if (jsu_pkg::room(c, lim, 3'd1)) begin
							ob[n[1:0]] = jsu_pkg::CH_QMARK; n = n + 3'd1; c = c + 1'b1;
						end
						mode_n  = jsu_pkg::MODE_TEXT;
						do_text = 1'b1;
					end
				end
				jsu_pkg::MODE_LOW_U: begin
					if (b == jsu_pkg::CH_LOW_U) begin
						mode_n = jsu_pkg::MODE_HEX2;
						hc_n   = 3'd0;
						u2_n   = '0;
					end else begin
						if (jsu_pkg::room(c, lim, 3'd1)) begin
							ob[n[1:0]] = jsu_pkg::CH_QMARK; n = n + 3'd1; c = c + 1'b1;
						end
						// replay the held backslash, then this byte as its escape
						mode_n     = jsu_pkg::MODE_TEXT;
						do_text    = 1'b1;
						tb         = jsu_pkg::CH_BSLASH;
						esc_follow = 1'b1;
					end
				end
				jsu_pkg::MODE_HEX2: begin
					if (!hv[4]) begin
						mode_n = jsu_pkg::MODE_TEXT;
						if (jsu_pkg::room(c, lim, 3'd1)) begin
							ob[n[1:0]] = jsu_pkg::CH_QMARK; n = n + 3'd1; c = c + 1'b1;
						end
					end else begin
						u2_n = {u2_q[11:0], hv[3:0]};
						hc_n = hc_q + 3'd1;
						if (hc_q == 3'd3) begin
							mode_n = jsu_pkg::MODE_TEXT;
							if (u1_q <= jsu_pkg::SUR_HI_END && u2_n >= jsu_pkg::SUR_LOW &&
									u2_n <= jsu_pkg::SUR_END) begin
								cp = jsu_pkg::SUPP_BASE + {1'b0, u1_q[9:0], u2_n[9:0]};
								if (jsu_pkg::room(c, lim, 3'd4)) begin
									ob[n[1:0]] = jsu_pkg::UTF_LEAD4 | {5'd0, cp[20:18]};
									n = n + 3'd1; c = c + 1'b1;
									ob[n[1:0]] = jsu_pkg::UTF_CONT | {2'd0, cp[17:12]};
									n = n + 3'd1; c = c + 1'b1;
									ob[n[1:0]] = jsu_pkg::UTF_CONT | {2'd0, cp[11:6]};
									n = n + 3'd1; c = c + 1'b1;
									ob[n[1:0]] = jsu_pkg::UTF_CONT | {2'd0, cp[5:0]};
									n = n + 3'd1; c = c + 1'b1;
								end
							end else if (jsu_pkg::room(c, lim, 3'd1)) begin
								ob[n[1:0]] = jsu_pkg::CH_QMARK; n = n + 3'd1; c = c + 1'b1;
							end
						end
					end
				end
				default: begin
					mode_n  = jsu_pkg::MODE_TEXT;
					do_text = 1'b1;
				end
			endcase
		end

		// plain text byte
		if (do_text) begin
			if (stop_n || !jsu_pkg::room(c, lim, 3'd1)) begin
				stop_n = 1'b1;
			end else if (tb == jsu_pkg::CH_BSLASH) begin
				mode_n = jsu_pkg::MODE_ESC;
				do_esc = esc_follow;
			end else begin
				ob[n[1:0]] = tb; n = n + 3'd1; c = c + 1'b1;
			end
		end

		// byte after a backslash
		if (do_esc) begin
			mode_n = jsu_pkg::MODE_TEXT;
			unique case (b)
				jsu_pkg::CH_LOW_N: m = jsu_pkg::CH_LF;
				jsu_pkg::CH_LOW_T: m = jsu_pkg::CH_TAB;
				jsu_pkg::CH_LOW_R: m = jsu_pkg::CH_CR;
				jsu_pkg::CH_LOW_B: m = jsu_pkg::CH_BS;
				jsu_pkg::CH_LOW_F: m = jsu_pkg::CH_FF;
				default:           m = b;
			endcase
			if (b == jsu_pkg::CH_LOW_U) begin
				mode_n = jsu_pkg::MODE_HEX1;
				hc_n   = 3'd0;
				u1_n   = '0;
			end else if (jsu_pkg::room(c, lim, 3'd1)) begin
				ob[n[1:0]] = m; n = n + 3'd1; c = c + 1'b1;
			end
		end

		// end of string: a pending low half becomes '?'
		if (item.string_end) begin
			if (mode_n == jsu_pkg::MODE_LOW_BS || mode_n == jsu_pkg::MODE_LOW_U ||
					mode_n == jsu_pkg::MODE_HEX2) begin
				if (jsu_pkg::room(c, lim, 3'd1)) begin
					ob[n[1:0]] = jsu_pkg::CH_QMARK; n = n + 3'd1; c = c + 1'b1;
				end
			end
		end
	end

	always_comb begin
		cmd.nbytes  = n;
		cmd.data    = ob;
		cmd.has_end = item.string_end;
		cmd.length  = item.string_end ? 16'(c) : 16'd0;
	end

	assign push = accept && (n != 3'd0 || item.string_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jsu_pkg::MODE_TEXT;
			hc_q   <= '0;
			u1_q   <= '0;
			u2_q   <= '0;
			cnt_q  <= '0;
			stop_q <= 1'b0;
		end else if (accept) begin
			if (item.string_end) begin
				mode_q <= jsu_pkg::MODE_TEXT;
				hc_q   <= '0;
				u1_q   <= '0;
				u2_q   <= '0;
				cnt_q  <= '0;
				stop_q <= 1'b0;
			end else begin
				mode_q <= mode_n;
				hc_q   <= hc_n;
				u1_q   <= u1_n;
				u2_q   <= u2_n;
				cnt_q  <= c[jsu_pkg::COUNT_BITS-1:0];
				stop_q <= stop_n;
			end
		end
	end

	// the capacity stop is only ever taken from text mode
	a_stop_in_text: assert property (@(posedge clk) disable iff (!arst_n)
		stop_q |-> mode_q == jsu_pkg::MODE_TEXT)
		else $error("stop flag set outside text mode");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && item.string_end) |=> (cnt_q == '0 && !stop_q))
		else $error("string end did not clear the count");

endmodule

`default_nettype wire

[rtl/jsu_queue.sv]
// small command queue between the decode front and the result back end
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire jsu_pkg::cmd_t wdata,
	input  wire logic          pop,
	output jsu_pkg::cmd_t      head,
	output logic               nonempty,
	output logic               full
);

	jsu_pkg::cmd_t                entry_q [jsu_pkg::Q_DEPTH];
	logic [jsu_pkg::Q_PTR_W-1:0]  wr_q, rd_q;
	logic [jsu_pkg::Q_PTR_W:0]    count_q;

	function automatic logic [jsu_pkg::Q_PTR_W-1:0] nxt(input logic [jsu_pkg::Q_PTR_W-1:0] p);
		return (p == jsu_pkg::Q_PTR_W'(jsu_pkg::Q_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head     = entry_q[rd_q];
	assign nonempty = count_q != '0;
	assign full     = count_q == (jsu_pkg::Q_PTR_W + 1)'(jsu_pkg::Q_DEPTH);

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= nxt(wr_q);
			end
			if (pop) begin
				rd_q <= nxt(rd_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count did not follow a push");

endmodule

`default_nettype wire

[rtl/jsu_back.sv]
// back end: walks each queued command, one result beat per cycle unless stalled
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire jsu_pkg::cmd_t head,
	input  wire logic          nonempty,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_stall,
	output jsu_pkg::out_item_t result
);

	logic [2:0]         idx_q;
	logic               vld_q;
	jsu_pkg::out_item_t res_q, res_n;
	logic               load, last_of_cmd, is_byte;

	assign is_byte     = idx_q < head.nbytes;
	assign last_of_cmd = is_byte ? ((idx_q + 3'd1 == head.nbytes) && !head.has_end) : 1'b1;
	assign load        = nonempty && (!vld_q || !result_stall);
	assign pop         = load && last_of_cmd;

	always_comb begin
		if (is_byte) begin
			res_n.out_byte   = head.data[idx_q[1:0]];
			res_n.is_end     = 1'b0;
			res_n.out_length = '0;
		end else begin
			res_n.out_byte   = '0;
			res_n.is_end     = 1'b1;
			res_n.out_length = head.length;
		end
		res_n.run_last = last_of_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else begin
			if (!vld_q || !result_stall) begin
				vld_q <= nonempty;
			end
			if (load) begin
				idx_q <= last_of_cmd ? 3'd0 : idx_q + 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_n;
		end
	end

	assign result_valid = vld_q;
	assign result       = res_q;

	a_end_beat: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_q && res_q.is_end) |-> (res_q.run_last && res_q.out_byte == 8'd0))
		else $error("end beat malformed");

endmodule

`default_nettype wire

[tb/sv/jsu_unescape_checker.sv]
// checker for the json string unescaper: predicts utf-8 output beats and compares them
`timescale 1ns / 1ps

module jsu_unescape_checker (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic               pready,
	input  wire logic [2:0]         paddr,
	input  wire logic [31:0]        pwdata,
	input  wire logic               item_valid,
	input  wire logic               item_stall,
	input  wire jsu_pkg::in_item_t  item,
	input  wire logic               result_valid,
	input  wire logic               result_stall,
	input  wire jsu_pkg::out_item_t result,
	output int                      err_count,
	output int                      backlog
);
	import jsu_pkg::*;

	localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	logic [15:0] cap_q;
	logic [2:0]  mode_q;
	logic [2:0]  ndig_q;
	logic [15:0] hi_q;
	logic [15:0] lo_q;
	int unsigned wcount;
	bit          halted;
	int          n_err = 0;

	out_item_t utf8_expected[$];
	out_item_t beat_buf[$];

	function automatic longint unsigned usable_cap();
		longint unsigned ceiling;
		ceiling = longint'(1) << COUNT_BITS;
		return (cap_q < ceiling) ? cap_q : ceiling;
	endfunction

	function automatic bit fits(int n);
		return (longint'(wcount) + n) < usable_cap();
	endfunction

	function automatic int nibble_of(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "a" && b <= "f") return b - "a" + 10;
		if (b >= "A" && b <= "F") return b - "A" + 10;
		return -1;
	endfunction

	task automatic report_mismatch(string msg);
		$display("ERROR at %0t: %s", $time, msg);
		n_err++;
	endtask

	task automatic put_byte(logic [7:0] b);
		out_item_t r;
		r = '0;
		r.out_byte = b;
		beat_buf.push_back(r);
		wcount++;
	endtask

	task automatic put_qmark();
		if (fits(1)) put_byte(CH_QMARK);
	endtask

	task automatic clear_string();
		mode_q = MODE_TEXT;
		ndig_q = '0;
		hi_q = '0;
		lo_q = '0;
		wcount = 0;
		halted = 1'b0;
	endtask

	task automatic take_text(logic [7:0] b);
		// once a new element would not fit, the rest of the string is dropped
		if (halted || !fits(1)) begin
			halted = 1'b1;
			return;
		end
		if (b == CH_BSLASH) mode_q = MODE_ESC;
		else put_byte(b);
	endtask

	task automatic take_escape(logic [7:0] b);
		logic [7:0] m;
		m = b;
		mode_q = MODE_TEXT;
		case (b)
			CH_LOW_N: m = CH_LF;
			CH_LOW_T: m = CH_TAB;
			CH_LOW_R: m = CH_CR;
			CH_LOW_B: m = CH_BS;
			CH_LOW_F: m = CH_FF;
			CH_LOW_U: begin
				mode_q = MODE_HEX1;
				ndig_q = '0;
				hi_q = '0;
				return;
			end
			default: ;
		endcase
		if (fits(1)) put_byte(m);
	endtask

	task automatic close_first();
		logic [15:0] c;
		c = hi_q;
		mode_q = MODE_TEXT;
		if (c < 16'h0080) begin
			if (fits(1)) put_byte(c[7:0]);
		end else if (c < 16'h0800) begin
			if (fits(2)) begin
				put_byte(UTF_LEAD2 | 8'(c >> 6));
				put_byte(UTF_CONT | 8'(c & 16'h3F));
			end
		end else if (c >= SUR_LO && c <= SUR_END) begin
			mode_q = MODE_LOW_BS;
		end else if (fits(3)) begin
			put_byte(UTF_LEAD3 | 8'(c >> 12));
			put_byte(UTF_CONT | 8'((c >> 6) & 16'h3F));
			put_byte(UTF_CONT | 8'(c & 16'h3F));
		end
	endtask

	task automatic close_pair();
		logic [20:0] cp;
		mode_q = MODE_TEXT;
		// a lone low half in the first unit ends up here as a broken pair when a full second unit follows
		if (hi_q <= SUR_HI_END && lo_q >= SUR_LOW && lo_q <= SUR_END) begin
			cp = SUPP_BASE + (21'(hi_q - SUR_LO) << 10) + 21'(lo_q - SUR_LOW);
			if (fits(4)) begin
				put_byte(UTF_LEAD4 | 8'(cp >> 18));
				put_byte(UTF_CONT | 8'((cp >> 12) & 21'h3F));
				put_byte(UTF_CONT | 8'((cp >> 6) & 21'h3F));
				put_byte(UTF_CONT | 8'(cp & 21'h3F));
			end
		end else begin
			put_qmark();
		end
	endtask

	task automatic take_byte(logic [7:0] b);
		int h;
		case (mode_q)
			MODE_ESC: take_escape(b);
			MODE_HEX1: begin
				h = nibble_of(b);
				if (h < 0) begin
					mode_q = MODE_TEXT;
				end else begin
					hi_q = {hi_q[11:0], 4'(h)};
					ndig_q++;
					if (ndig_q >= 3'd4) close_first();
				end
			end
			MODE_LOW_BS: begin
				if (b == CH_BSLASH) begin
					mode_q = MODE_LOW_U;
				end else begin
					put_qmark();
					mode_q = MODE_TEXT;
					take_text(b);
				end
			end
			MODE_LOW_U: begin
				if (b == CH_LOW_U) begin
					mode_q = MODE_HEX2;
					ndig_q = '0;
					lo_q = '0;
				end else begin
					// backslash and this byte are replayed as an ordinary escape
					put_qmark();
					mode_q = MODE_TEXT;
					take_text(CH_BSLASH);
					if (mode_q == MODE_ESC) take_escape(b);
				end
			end
			MODE_HEX2: begin
				h = nibble_of(b);
				if (h < 0) begin
					mode_q = MODE_TEXT;
					put_qmark();
				end else begin
					lo_q = {lo_q[11:0], 4'(h)};
					ndig_q++;
					if (ndig_q >= 3'd4) close_pair();
				end
			end
			default: begin
				mode_q = MODE_TEXT;
				take_text(b);
			end
		endcase
	endtask

	task automatic predict_item(in_item_t it);
		out_item_t tail;
		beat_buf.delete();
		if (it.byte_valid && !halted) take_byte(it.in_byte);
		if (it.string_end) begin
			// an unfinished low half still owes a '?'
			if (mode_q == MODE_LOW_BS || mode_q == MODE_LOW_U || mode_q == MODE_HEX2)
				put_qmark();
			tail = '0;
			tail.is_end = 1'b1;
			tail.out_length = 16'(wcount);
			beat_buf.push_back(tail);
			clear_string();
		end
		if (beat_buf.size() > 0) beat_buf[beat_buf.size() - 1].run_last = 1'b1;
		foreach (beat_buf[i]) utf8_expected.push_back(beat_buf[i]);
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		if (utf8_expected.size() == 0) begin
			report_mismatch($sformatf("result beat with nothing expected: %h", got));
			return;
		end
		want = utf8_expected.pop_front();
		if (got.out_byte !== want.out_byte)
			report_mismatch($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
		if (got.run_last !== want.run_last)
			report_mismatch($sformatf("run_last %b, expected %b", got.run_last, want.run_last));
		if (got.is_end !== want.is_end)
			report_mismatch($sformatf("is_end %b, expected %b", got.is_end, want.is_end));
		if (got.out_length !== want.out_length)
			report_mismatch($sformatf("out_length %0d, expected %0d",
				got.out_length, want.out_length));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q = CAP_RESET;
			clear_string();
			utf8_expected.delete();
		end else begin
			if (psel && penable && pwrite && pready && paddr == CAP_ADDR)
				cap_q = pwdata[15:0];
			if (item_valid && !item_stall) predict_item(item);
			if (result_valid && !result_stall) check_result(result);
		end
		backlog = utf8_expected.size();
		err_count = n_err;
	end

endmodule

[tb/sv/testbench.sv]
// testbench top for the json string unescaper: stimulus, capacity phases and verdict
`timescale 1ns / 1ps

module testbench;
	import jsu_pkg::*;

	localparam logic [2:0] CAP_ADDR = {REG_CAPACITY, 2'b00};

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid;
	logic        item_stall;
	in_item_t    item;
	logic        result_valid;
	logic        result_stall;
	out_item_t   result;
	int          err_count;
	int          backlog;

	int          tx_calm = 0;
	int          sent = 0;
	in_item_t    str_q[$];

	json_string_unescape_utf8_top i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.prdata       (prdata),
		.pready       (pready),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	jsu_unescape_checker i_check (
		.clk          (clk),
		.arst_n       (arst_n),
		.psel         (psel),
		.penable      (penable),
		.pwrite       (pwrite),
		.pready       (pready),
		.paddr        (paddr),
		.pwdata       (pwdata),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.err_count    (err_count),
		.backlog      (backlog)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("DONE: errors detected");
		$finish;
	end

	// random wait with occasional stretches of back-to-back beats
	function automatic int pick_gap(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 5) == 0) run = $urandom_range(8, 30);
		return $urandom_range(0, 18);
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return "0" + 8'(n);
		return ($urandom_range(0, 1) ? "A" : "a") + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255));
		while ((v >= "0" && v <= "9") || (v >= "a" && v <= "f") || (v >= "A" && v <= "F"));
		return v;
	endfunction

	function automatic logic [7:0] pick_escape();
		case ($urandom_range(0, 8))
			0: return CH_LOW_N;
			1: return CH_LOW_T;
			2: return CH_LOW_R;
			3: return CH_LOW_B;
			4: return CH_LOW_F;
			5: return "\"";
			6: return "/";
			7: return CH_BSLASH;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin : drain
		int hold;
		int taken;
		int rx_calm;
		result_stall = 1'b0;
		taken = 0;
		rx_calm = 0;
		forever begin
			// two long holds let the command queue fill and push back on the sender
			if (taken == 30 || taken == 200) hold = 400;
			else hold = pick_gap(rx_calm);
			if (hold > 0) begin
				result_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			result_stall <= 1'b0;
			do @(posedge clk); while (!result_valid);
			taken++;
		end
	end

	task automatic send_item(in_item_t it);
		int gap;
		gap = pick_gap(tx_calm);
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
	endtask

	task automatic wait_drained();
		item_valid <= 1'b0;
		do @(negedge clk); while (backlog != 0);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_capacity(logic [15:0] v);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= CAP_ADDR;
		pwdata <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic add_byte(logic [7:0] b);
		str_q.push_back(in_item_t'{b, 1'b1, 1'b0});
	endtask

	task automatic add_text(string s);
		for (int i = 0; i < s.len(); i++) add_byte(s[i]);
	endtask

	task automatic add_unit(logic [15:0] v);
		add_byte(CH_BSLASH);
		add_byte(CH_LOW_U);
		for (int k = 3; k >= 0; k--) add_byte(hex_char(v[4*k +: 4]));
	endtask

	task automatic add_bad_digits();
		repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
		add_byte(non_hex());
	endtask

	// close the string on its last byte or with an empty end beat, then send it
	task automatic ship_string(bit on_byte);
		if (on_byte && str_q.size() > 0)
			str_q[str_q.size() - 1].string_end = 1'b1;
		else
			str_q.push_back(in_item_t'{8'($urandom_range(0, 255)), 1'b0, 1'b1});
		foreach (str_q[i]) begin
			if ($urandom_range(0, 29) == 0)
				send_item(in_item_t'{8'($urandom_range(0, 255)), 1'b0, 1'b0});
			send_item(str_q[i]);
			sent++;
		end
		str_q.delete();
	endtask

	task automatic add_token();
		int pick;
		logic [15:0] hi;
		logic [15:0] lo;
		pick = $urandom_range(0, 99);
		hi = 16'($urandom_range(SUR_LO, SUR_END));
		if (pick < 40) begin
			add_byte(8'($urandom_range(0, 255)));
		end else if (pick < 55) begin
			add_byte(CH_BSLASH);
			add_byte(pick_escape());
		end else if (pick < 70) begin
			case ($urandom_range(0, 3))
				0: add_unit(16'($urandom_range(0, 16'h007F)));
				1: add_unit(16'($urandom_range(16'h0080, 16'h07FF)));
				2: add_unit(16'($urandom_range(16'h0800, 16'hD7FF)));
				default: add_unit(16'($urandom_range(16'hE000, 16'hFFFF)));
			endcase
		end else if (pick < 85) begin
			add_unit(16'($urandom_range(SUR_LO, SUR_HI_END)));
			add_unit(16'($urandom_range(SUR_LOW, SUR_END)));
		end else if (pick < 95) begin
			add_unit(hi);
			case ($urandom_range(0, 3))
				0: add_byte(8'($urandom_range(0, 255)));
				1: begin
					add_byte(CH_BSLASH);
					add_byte(pick_escape());
				end
				2: begin
					lo = 16'($urandom_range(0, 16'hFFFF));
					if (lo >= SUR_LOW && lo <= SUR_END) lo = lo ^ 16'h0400;
					add_unit(lo);
				end
				default: begin
					add_byte(CH_BSLASH);
					add_byte(CH_LOW_U);
					add_bad_digits();
				end
			endcase
		end else begin
			add_byte(CH_BSLASH);
			add_byte(CH_LOW_U);
			add_bad_digits();
		end
	endtask

	task automatic build_string();
		int cut;
		repeat ($urandom_range(0, 8)) add_token();
		// sometimes end the string in the middle of an escape
		if (str_q.size() > 0 && $urandom_range(0, 5) == 0) begin
			cut = $urandom_range(1, 5);
			while (cut > 0 && str_q.size() > 0) begin
				void'(str_q.pop_back());
				cut--;
			end
		end
		ship_string($urandom_range(0, 2) != 0);
	endtask

	initial begin : stimulus
		logic [15:0] caps[9];
		int phase_base;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		item_valid = 1'b0;
		item = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// byte extremes, a simple escape, 2-byte and 4-byte sequences, empty end beat
		add_byte(8'h00);
		add_byte(8'hFF);
		add_text("\\n\\u00e9\\uD83D\\ude00");
		ship_string(1'b0);
		send_item(in_item_t'{8'hA5, 1'b0, 1'b0});
		// lone low half, missing backslash after it, invalid digit ending the string
		add_text("\\uDC00x\\u0G");
		ship_string(1'b1);

		caps = '{16'd1, 16'd2, 16'd3, 16'd5, 16'd8, 16'd65535,
			16'($urandom_range(4, 40)), 16'($urandom_range(41, 300)), CAP_RESET};
		foreach (caps[p]) begin
			wait_drained();
			write_capacity(caps[p]);
			phase_base = sent;
			while (sent - phase_base < 16) build_string();
		end

		wait_drained();
		if (err_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

[files.f]
rtl/jsu_pkg.sv
rtl/jsu_front.sv
rtl/jsu_queue.sv
rtl/jsu_back.sv
rtl/json_string_unescape_utf8_top.sv
tb/sv/jsu_unescape_checker.sv
tb/sv/testbench.sv
